>>> src/lls_pkg.sv
// lls_pkg: shared types, widths and codes for the line layer mesh-size block
// used by lls_table, lls_core and line_layer_mesh_size; no dependencies
`default_nettype none
package lls_pkg;

  // operation carried in tuser of the input channel
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_END_A_X       = 3'd0;
  localparam logic [2:0] CFG_END_A_Y       = 3'd1;
  localparam logic [2:0] CFG_END_A_Z       = 3'd2;
  localparam logic [2:0] CFG_END_B_X       = 3'd3;
  localparam logic [2:0] CFG_END_B_Y       = 3'd4;
  localparam logic [2:0] CFG_END_B_Z       = 3'd5;
  localparam logic [2:0] CFG_LAYER_COUNT   = 3'd6;

  // difference vectors need 35 bits signed, magnitudes 34 bits
  typedef logic signed [34:0] vec_t;
  typedef logic        [33:0] mag_t;
  typedef logic        [67:0] prod_t;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
  } seg_t;

  typedef struct packed {
    logic        wr_en;
    logic [3:0]  wr_idx;
    logic [31:0] wr_radius;
    logic [31:0] wr_edge;
  } tbl_wr_t;

  typedef struct packed {
    logic [31:0] radius;
    logic [31:0] edge_len;
  } tbl_entry_t;

  typedef struct packed {
    logic [31:0] edge_len;
    logic        uncovered;
  } res_t;

  function automatic mag_t mag_of(vec_t v);
    vec_t n;
    n = -v;
    return v[34] ? mag_t'(n) : mag_t'(v);
  endfunction

endpackage
`default_nettype wire

>>> src/lls_table.sv
// lls_table: layer table memory, one entry of radius and edge length per layer
// one write port, one read port with registered data; uses lls_pkg
`default_nettype none
module lls_table #(
  parameter int MAX_LAYERS = 16,
  parameter int AW         = 4
) (
  input  wire logic                clk,
  input  wire lls_pkg::tbl_wr_t    wr,
  input  wire logic [AW-1:0]       rd_addr,
  output      lls_pkg::tbl_entry_t rd_data
);
  import lls_pkg::*;

  tbl_entry_t      mem [MAX_LAYERS];
  logic [AW-1:0]   wr_addr;
  logic            wr_ok;

  assign wr_addr = AW'(wr.wr_idx);
  assign wr_ok   = wr.wr_en && (32'(wr.wr_idx) < MAX_LAYERS);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= '{radius: wr.wr_radius, edge_len: wr.wr_edge};
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> src/lls_core.sv
// lls_core: sequencer and shared datapath (multiplier, square root, divider)
// for one query or table write at a time; uses lls_pkg, drives lls_table
`default_nettype none
module lls_core #(
  parameter int AW         = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                op,
  input  wire logic signed [31:0]  point_x,
  input  wire logic signed [31:0]  point_y,
  input  wire logic signed [31:0]  point_z,
  input  wire logic [3:0]          layer_index,
  input  wire logic [31:0]         layer_radius,
  input  wire logic [31:0]         layer_edge,
  input  wire lls_pkg::seg_t       seg,
  input  wire logic [AW-1:0]       last_idx,
  output      logic                idle,
  output      lls_pkg::tbl_wr_t    tbl_wr,
  output      logic [AW-1:0]       tbl_rd_addr,
  input  wire lls_pkg::tbl_entry_t tbl_rd_data,
  output      logic                res_valid,
  input  wire logic                res_ready,
  output      lls_pkg::res_t       res
);
  import lls_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_SQ    = 14'b00000000000010,
    S_SQRT  = 14'b00000000000100,
    S_MRD0  = 14'b00000000001000,
    S_MCHK0 = 14'b00000000010000,
    S_MSRCH = 14'b00000000100000,
    S_MMUL  = 14'b00000001000000,
    S_MDIV  = 14'b00000010000000,
    S_TAKE  = 14'b00000100000000,
    S_DOT   = 14'b00001000000000,
    S_TCHK  = 14'b00010000000000,
    S_TDIV  = 14'b00100000000000,
    S_FOOT  = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  localparam logic [1:0] PH_END_A = 2'd0;
  localparam logic [1:0] PH_END_B = 2'd1;
  localparam logic [1:0] PH_FOOT  = 2'd2;

  state_t             state_r;
  logic [1:0]         phase_r;
  logic [2:0]         cnt_r;
  logic [5:0]         step_r;
  vec_t               va_r [3];
  vec_t               vb_r [3];
  vec_t               u_r  [3];
  vec_t               w_r  [3];
  vec_t               cur_v [3];
  mag_t               mul_a, mul_b;
  prod_t              prod_r;
  logic [67:0]        acc_r;
  logic [35:0]        rem_r;
  logic [33:0]        root_r;
  logic [37:0]        sq_remt, sq_trial;
  logic               sq_ge;
  logic [AW-1:0]      idx_r;
  logic               found_r;
  tbl_entry_t         hi_r;
  logic [31:0]        lo_e_r, num_r, den_r, dm_r, val_r, best_r;
  logic               neg_r, hit_r, covered_r;
  logic signed [67:0] dot_r;
  logic [67:0]        len2_r;
  logic [66:0]        drem_r;
  logic [32:0]        quo_r;
  logic [31:0]        nsh_r;
  logic [67:0]        div_r2, div_d, div_diff;
  logic               div_ge;
  logic [32:0]        div_q;
  logic [31:0]        div_val;
  logic [1:0]         kp;
  logic [67:0]        nfull, fsum;
  vec_t               f_v;
  logic               take_upd;
  logic [31:0]        best_n;
  logic               cov_n;
  res_t               res_r;

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  assign tbl_wr.wr_en     = idle && start && (op == OP_WRITE);
  assign tbl_wr.wr_idx    = layer_index;
  assign tbl_wr.wr_radius = layer_radius;
  assign tbl_wr.wr_edge   = layer_edge;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (phase_r == PH_END_A) cur_v[k] = va_r[k];
      else if (phase_r == PH_END_B) cur_v[k] = vb_r[k];
      else cur_v[k] = w_r[k];
    end
  end

  // index of the product that arrives this cycle
  assign kp = 2'(cnt_r - 3'd1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQ: begin
        if (cnt_r < 3'd3) begin
          mul_a = mag_of(cur_v[cnt_r[1:0]]);
          mul_b = mag_of(cur_v[cnt_r[1:0]]);
        end
      end
      S_DOT: begin
        if (cnt_r < 3'd3) begin
          mul_a = mag_of(va_r[cnt_r[1:0]]);
          mul_b = mag_of(u_r[cnt_r[1:0]]);
        end else if (cnt_r < 3'd6) begin
          mul_a = mag_of(u_r[2'(cnt_r - 3'd3)]);
          mul_b = mag_of(u_r[2'(cnt_r - 3'd3)]);
        end
      end
      S_MMUL: begin
        mul_a = 34'(dm_r);
        mul_b = 34'(num_r);
      end
      S_FOOT: begin
        if (cnt_r < 3'd3) begin
          mul_a = 34'(quo_r);
          mul_b = mag_of(u_r[cnt_r[1:0]]);
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // one root bit per step
  assign sq_remt  = {rem_r, acc_r[67:66]};
  assign sq_trial = {2'b00, root_r, 2'b01};
  assign sq_ge    = (sq_remt >= sq_trial);

  // shared restoring divider step
  always_comb begin
    if (state_r == S_TDIV) begin
      div_r2 = {drem_r, 1'b0};
      div_d  = len2_r;
    end else begin
      div_r2 = {35'd0, drem_r[31:0], nsh_r[31]};
      div_d  = {36'd0, den_r};
    end
    div_ge   = (div_r2 >= div_d);
    div_diff = div_r2 - div_d;
    div_q    = {quo_r[31:0], div_ge};
    div_val  = neg_r ? (lo_e_r - div_q[31:0]) : (lo_e_r + div_q[31:0]);
  end

  assign nfull    = prod_r + {37'd0, den_r[31:1]};
  assign fsum     = prod_r + 68'h0_0000_0000_8000_0000;
  assign f_v      = vec_t'(fsum[66:32]);
  assign take_upd = hit_r && (!covered_r || (val_r < best_r));
  assign best_n   = take_upd ? val_r : best_r;
  assign cov_n    = covered_r || hit_r;

  always_comb begin
    unique case (state_r)
      S_MRD0:  tbl_rd_addr = '0;
      S_MCHK0: tbl_rd_addr = last_idx;
      S_MSRCH: tbl_rd_addr = idx_r - AW'(1);
      default: tbl_rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_END_A;
      cnt_r   <= '0;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (op == OP_WRITE) begin
              res_r   <= '{edge_len: '0, uncovered: 1'b0};
              state_r <= S_DONE;
            end else begin
              va_r[0] <= vec_t'(point_x) - vec_t'(seg.ax);
              va_r[1] <= vec_t'(point_y) - vec_t'(seg.ay);
              va_r[2] <= vec_t'(point_z) - vec_t'(seg.az);
              vb_r[0] <= vec_t'(point_x) - vec_t'(seg.bx);
              vb_r[1] <= vec_t'(point_y) - vec_t'(seg.by);
              vb_r[2] <= vec_t'(point_z) - vec_t'(seg.bz);
              u_r[0]  <= vec_t'(seg.bx) - vec_t'(seg.ax);
              u_r[1]  <= vec_t'(seg.by) - vec_t'(seg.ay);
              u_r[2]  <= vec_t'(seg.bz) - vec_t'(seg.az);
              phase_r   <= PH_END_A;
              cnt_r     <= '0;
              acc_r     <= '0;
              covered_r <= 1'b0;
              best_r    <= '0;
              state_r   <= S_SQ;
            end
          end
        end
        S_SQ: begin
          if (cnt_r != 3'd0) acc_r <= acc_r + prod_r;
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd3) begin
            rem_r   <= '0;
            root_r  <= '0;
            step_r  <= '0;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          rem_r  <= sq_ge ? 36'(sq_remt - sq_trial) : 36'(sq_remt);
          root_r <= {root_r[32:0], sq_ge};
          acc_r  <= {acc_r[65:0], 2'b00};
          step_r <= step_r + 6'd1;
          if (step_r == 6'd33) state_r <= S_MRD0;
        end
        S_MRD0: state_r <= S_MCHK0;
        S_MCHK0: begin
          if (root_r <= {2'b00, tbl_rd_data.radius}) begin
            val_r   <= tbl_rd_data.edge_len;
            hit_r   <= 1'b1;
            state_r <= S_TAKE;
          end else begin
            idx_r   <= last_idx;
            found_r <= 1'b0;
            state_r <= S_MSRCH;
          end
        end
        S_MSRCH: begin
          if (root_r <= {2'b00, tbl_rd_data.radius}) begin
            found_r <= 1'b1;
            hi_r    <= tbl_rd_data;
            idx_r   <= idx_r - AW'(1);
          end else if (!found_r) begin
            hit_r   <= 1'b0;
            state_r <= S_TAKE;
          end else begin
            // the failing entry sits just below the one found
            num_r   <= root_r[31:0] - tbl_rd_data.radius;
            den_r   <= hi_r.radius - tbl_rd_data.radius;
            neg_r   <= hi_r.edge_len < tbl_rd_data.edge_len;
            dm_r    <= (hi_r.edge_len < tbl_rd_data.edge_len)
                       ? tbl_rd_data.edge_len - hi_r.edge_len
                       : hi_r.edge_len - tbl_rd_data.edge_len;
            lo_e_r  <= tbl_rd_data.edge_len;
            cnt_r   <= '0;
            state_r <= S_MMUL;
          end
        end
        S_MMUL: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd1) begin
            drem_r  <= 67'(nfull[64:32]);
            nsh_r   <= nfull[31:0];
            quo_r   <= '0;
            step_r  <= '0;
            state_r <= S_MDIV;
          end
        end
        S_MDIV: begin
          drem_r <= div_ge ? div_diff[66:0] : div_r2[66:0];
          quo_r  <= div_q;
          nsh_r  <= {nsh_r[30:0], 1'b0};
          step_r <= step_r + 6'd1;
          if (step_r == 6'd31) begin
            val_r   <= div_val;
            hit_r   <= 1'b1;
            state_r <= S_TAKE;
          end
        end
        S_TAKE: begin
          best_r    <= best_n;
          covered_r <= cov_n;
          cnt_r     <= '0;
          unique case (phase_r)
            PH_END_A: begin
              phase_r <= PH_END_B;
              acc_r   <= '0;
              state_r <= S_SQ;
            end
            PH_END_B: begin
              dot_r   <= '0;
              len2_r  <= '0;
              state_r <= S_DOT;
            end
            default: begin
              res_r   <= '{edge_len: cov_n ? best_n : '1, uncovered: !cov_n};
              state_r <= S_DONE;
            end
          endcase
        end
        S_DOT: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r >= 3'd1 && cnt_r <= 3'd3) begin
            if (va_r[kp][34] != u_r[kp][34]) dot_r <= dot_r - signed'(prod_r);
            else dot_r <= dot_r + signed'(prod_r);
          end else if (cnt_r >= 3'd4) begin
            len2_r <= len2_r + prod_r;
          end
          if (cnt_r == 3'd6) state_r <= S_TCHK;
        end
        S_TCHK: begin
          step_r <= '0;
          if (len2_r != '0 && !dot_r[67] && $unsigned(dot_r) <= len2_r) begin
            if ($unsigned(dot_r) == len2_r) begin
              quo_r  <= 33'd1;
              drem_r <= '0;
            end else begin
              quo_r  <= '0;
              drem_r <= dot_r[66:0];
            end
            state_r <= S_TDIV;
          end else begin
            res_r   <= '{edge_len: covered_r ? best_r : '1, uncovered: !covered_r};
            state_r <= S_DONE;
          end
        end
        S_TDIV: begin
          drem_r <= div_ge ? div_diff[66:0] : div_r2[66:0];
          quo_r  <= div_q;
          step_r <= step_r + 6'd1;
          if (step_r == 6'd31) begin
            cnt_r   <= '0;
            state_r <= S_FOOT;
          end
        end
        S_FOOT: begin
          if (cnt_r != 3'd0) begin
            w_r[kp] <= u_r[kp][34] ? (va_r[kp] + f_v) : (va_r[kp] - f_v);
          end
          if (cnt_r == 3'd3) begin
            phase_r <= PH_FOOT;
            cnt_r   <= '0;
            acc_r   <= '0;
            state_r <= S_SQ;
          end else begin
            cnt_r <= cnt_r + 3'd1;
          end
        end
        S_DONE: begin
          if (res_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_ready) |=> (state_r == S_IDLE))
    else $error("result handed over but sequencer did not return to idle");

  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start && op == OP_WRITE) |=>
      (state_r == S_DONE && res_r.edge_len == '0 && !res_r.uncovered))
    else $error("table write did not produce a zero result");

  a_uncovered_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_r.uncovered) |-> (res_r.edge_len == '1))
    else $error("uncovered result not saturated");

endmodule
`default_nettype wire

>>> src/line_layer_mesh_size.sv
// line_layer_mesh_size: top level with stream channels, configuration registers
// and output register; instantiates lls_core and lls_table, uses lls_pkg
//
// usage: segment ends and layer count are set through the cfg write port while
// the block is idle; the user must keep to this, as the block does not enforce
// it. each input transaction either writes one layer table entry (tuser 0) or
// queries one point (tuser 1); each gives exactly one output transaction. a
// write answers with edge 0. a query runs the shared 34x34 multiplier, a
// 34-step square root and a 32-step divider in sequence: per distance the
// square root is followed by the layer search (one table read per layer, up to
// layer_count) and, when interpolating, the divider; the dot product, the
// 32-step projection divide and the foot point follow. one item is in work at
// a time; the next is taken as soon as the sequencer is idle, even while a
// result waits in the output register. a stalled receiver holds the result
// and, once the sequencer has a second one, stops intake. reset clears the
// configuration (ends at origin, one layer) and the channels; the table holds
// no defined contents until written
`default_nettype none
module line_layer_mesh_size #(
  parameter int MAX_LAYERS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  // point_x[31:0], point_y[63:32], point_z[95:64], layer_index[99:96],
  // layer_radius_in[131:100], layer_edge_in[163:132], zero pad
  input  wire logic [167:0] in_tdata,
  // op[0]
  input  wire logic [0:0]   in_tuser,
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  // edge_length[31:0]
  output      logic [31:0]  out_tdata,
  // uncovered[0]
  output      logic [0:0]   out_tuser,
  input  wire logic         cfg_wr_en,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata
);
  import lls_pkg::*;

  localparam int AW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

  seg_t          seg_r;
  logic [4:0]    lcnt_r;
  logic [8:0]    n_used;
  logic [AW-1:0] last_idx;
  logic          core_idle, start;
  tbl_wr_t       tbl_wr;
  logic [AW-1:0] tbl_rd_addr;
  tbl_entry_t    tbl_rd_data;
  logic          res_valid, res_ready;
  res_t          res;
  logic          out_valid_r;
  res_t          out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r  <= '0;
      lcnt_r <= 5'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_END_A_X:     seg_r.ax <= cfg_wdata;
        CFG_END_A_Y:     seg_r.ay <= cfg_wdata;
        CFG_END_A_Z:     seg_r.az <= cfg_wdata;
        CFG_END_B_X:     seg_r.bx <= cfg_wdata;
        CFG_END_B_Y:     seg_r.by <= cfg_wdata;
        CFG_END_B_Z:     seg_r.bz <= cfg_wdata;
        CFG_LAYER_COUNT: lcnt_r   <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // zero layers counts as one, too many as the table depth
  assign n_used = (lcnt_r == 5'd0) ? 9'd1
                : ((9'(lcnt_r) > 9'(MAX_LAYERS)) ? 9'(MAX_LAYERS) : 9'(lcnt_r));
  assign last_idx = AW'(n_used - 9'd1);

  // no transaction is taken while reset is held
  assign in_tready = core_idle && rst_n;
  assign start     = in_tvalid && in_tready;
  assign res_ready = !out_valid_r || out_tready;

  lls_core #(.AW(AW)) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .op           (in_tuser[0]),
    .point_x      (in_tdata[31:0]),
    .point_y      (in_tdata[63:32]),
    .point_z      (in_tdata[95:64]),
    .layer_index  (in_tdata[99:96]),
    .layer_radius (in_tdata[131:100]),
    .layer_edge   (in_tdata[163:132]),
    .seg          (seg_r),
    .last_idx     (last_idx),
    .idle         (core_idle),
    .tbl_wr       (tbl_wr),
    .tbl_rd_addr  (tbl_rd_addr),
    .tbl_rd_data  (tbl_rd_data),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  lls_table #(.MAX_LAYERS(MAX_LAYERS), .AW(AW)) u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && res_ready) out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.edge_len;
  assign out_tuser  = out_r.uncovered;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output register not empty after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_tready)
    else $error("intake still open while an item is in work");

  a_uncovered_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.uncovered) |-> (out_r.edge_len == '1))
    else $error("uncovered output not saturated");

endmodule
`default_nettype wire
